@@ hw/rtl/pol_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the positional ordered list
// no dependencies; imported by every other file of the block

package pol_pkg;

  // list geometry
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned WORD_BITS = 32;

  // field widths fixed by the item format
  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 5;

  // derived widths
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_READ       = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_PUSH_FRONT = 3'd4,
    OP_PUSH_BACK  = 3'd5,
    OP_POP_FRONT  = 3'd6,
    OP_POP_BACK   = 3'd7
  } pol_op_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic             ins;  // open a gap at pos, shift upward
    logic             rem;  // close the gap at pos, shift downward
    logic [CMP_W-1:0] pos;
  } pol_cmd_t;

  // decoded control for one item
  typedef struct packed {
    logic             ok;
    logic             ret;     // item returns a stored word
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] cnt;     // count after the item
  } pol_ctl_t;

endpackage

@@ hw/rtl/pol_in_if.sv @@
`timescale 1ns / 1ps
// input channel of the positional ordered list: valid/ready plus the item
// depends on pol_pkg

interface pol_in_if
  import pol_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [POS_W-1:0]     position;
  logic [WORD_BITS-1:0] new_value;

  modport source (output valid, output op, output position, output new_value,
                  input ready);
  modport sink   (input valid, input op, input position, input new_value,
                  output ready);
endinterface

@@ hw/rtl/pol_out_if.sv @@
`timescale 1ns / 1ps
// result channel of the positional ordered list: valid/ready plus the item
// depends on pol_pkg

interface pol_out_if
  import pol_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [WORD_BITS-1:0] read_value;
  logic [CNT_W-1:0]     count;
  logic                 empty_res;

  modport source (output valid, output ok, output read_value, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input ok, input read_value, input count,
                  input empty_res, output ready);
endinterface

@@ hw/rtl/pol_cell.sv @@
`timescale 1ns / 1ps
// one storage cell of the list chain: holds a word, takes a neighbor's word
// depends on pol_pkg

module pol_cell
  import pol_pkg::*;
(
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  pol_cmd_t             cmd_i,
  input  logic [WORD_BITS-1:0] new_value_i,
  input  logic [WORD_BITS-1:0] lower_i,
  input  logic [WORD_BITS-1:0] upper_i,
  output logic [WORD_BITS-1:0] data_o
);

  logic [WORD_BITS-1:0] data_q, data_d;
  logic [CMP_W-1:0]     idx;

  assign idx = CMP_W'(idx_i);

  // insert: cells above pos take the lower word, pos takes the new word
  // remove: cells at or above pos take the upper word
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx > cmd_i.pos) begin
        data_d = lower_i;
      end else if (idx == cmd_i.pos) begin
        data_d = new_value_i;
      end
    end else if (cmd_i.rem) begin
      if (idx >= cmd_i.pos) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/pol_ctrl.sv @@
`timescale 1ns / 1ps
// item decode: checks position against count, builds the shift command
// depends on pol_pkg

module pol_ctrl
  import pol_pkg::*;
(
  input  logic [OP_W-1:0]  op_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [CNT_W-1:0] count_i,
  output pol_cmd_t         cmd_o,
  output pol_ctl_t         ctl_o
);

  logic             full;
  logic             nonempty;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] cnt;
  logic [CMP_W-1:0] last;
  logic [CMP_W-1:0] sel;
  logic             ins;
  logic             rem;
  logic             ok;
  logic             ret;
  logic [CNT_W-1:0] cnt_next;

  assign pos      = CMP_W'(position_i);
  assign cnt      = CMP_W'(count_i);
  assign last     = cnt - CMP_W'(1);
  assign full     = (count_i == CNT_W'(CAPACITY));
  assign nonempty = (count_i != '0);

  // per-operation checks and target position
  always_comb begin
    ok  = 1'b0;
    ret = 1'b0;
    ins = 1'b0;
    rem = 1'b0;
    sel = '0;
    unique case (pol_op_e'(op_i))
      OP_INSERT: begin
        ok  = !full && (pos <= cnt);
        ins = 1'b1;
        sel = pos;
      end
      OP_REMOVE: begin
        ok  = (pos < cnt);
        ret = 1'b1;
        rem = 1'b1;
        sel = pos;
      end
      OP_READ: begin
        ok  = (pos < cnt);
        ret = 1'b1;
        sel = pos;
      end
      OP_CLEAR: begin
        ok = 1'b1;
      end
      OP_PUSH_FRONT: begin
        ok  = !full;
        ins = 1'b1;
      end
      OP_PUSH_BACK: begin
        ok  = !full;
        ins = 1'b1;
        sel = cnt;
      end
      OP_POP_FRONT: begin
        ok  = nonempty;
        ret = 1'b1;
        rem = 1'b1;
      end
      OP_POP_BACK: begin
        ok  = nonempty;
        ret = 1'b1;
        rem = 1'b1;
        sel = last;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // count after the item
  always_comb begin
    cnt_next = count_i;
    if (ok) begin
      if (pol_op_e'(op_i) == OP_CLEAR) begin
        cnt_next = '0;
      end else if (ins) begin
        cnt_next = count_i + CNT_W'(1);
      end else if (rem) begin
        cnt_next = count_i - CNT_W'(1);
      end
    end
  end

  assign ctl_o = '{ok: ok, ret: ret, rd_idx: sel[IDX_W-1:0], cnt: cnt_next};
  assign cmd_o = '{ins: ins && ok, rem: rem && ok, pos: sel};

endmodule

@@ hw/rtl/positional_ordered_list_top.sv @@
`timescale 1ns / 1ps
// top level of the positional ordered list: control, cell chain, result register
// depends on pol_pkg, pol_in_if, pol_out_if, pol_ctrl and pol_cell
//
// Usage:
//   in_i  carries one operation per item (op, position, new_value).
//   out_o returns one result item per input item (ok, read_value, count,
//   empty_res), in input order.
//   Each list slot is a cell of a chain; an insert shifts every cell above
//   the position up by one, a remove shifts them down by one, all in the
//   cycle the item is accepted. A read selects one cell's word.
//   The result is registered and valid in the cycle after the item is accepted.
//   Throughput: one item per cycle; the single result register sets it,
//   since a new item is taken only when that register is empty or being
//   drained in the same cycle.
//   When the receiver stalls, the result is held and in_i.ready drops
//   until it is taken; the list state does not change meanwhile.
//   Reset empties the list (count 0) and drops the result valid; the
//   stored words are not cleared, as only slots below the count are read.

module positional_ordered_list_top
  import pol_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pol_in_if.sink    in_i,
  pol_out_if.source out_o
);

  logic [CNT_W-1:0]     count_q;
  logic                 out_valid_q;
  logic                 ok_q;
  logic [WORD_BITS-1:0] read_value_q;
  logic [CNT_W-1:0]     res_count_q;
  logic                 accept;
  pol_cmd_t             cmd;
  pol_cmd_t             cell_cmd;
  pol_ctl_t             ctl;
  logic [WORD_BITS-1:0] cell_data [CAPACITY];
  logic [WORD_BITS-1:0] rd_word;

  // handshake: take an item when the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // item decode
  pol_ctrl u_ctrl (
    .op_i       (in_i.op),
    .position_i (in_i.position),
    .count_i    (count_q),
    .cmd_o      (cmd),
    .ctl_o      (ctl)
  );

  // shifts only happen on an accepted item
  always_comb begin
    cell_cmd     = cmd;
    cell_cmd.ins = cmd.ins && accept;
    cell_cmd.rem = cmd.rem && accept;
  end

  // chain of cells, each wired to its lower and upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower;
    logic [WORD_BITS-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    pol_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .cmd_i       (cell_cmd),
      .new_value_i (in_i.new_value),
      .lower_i     (lower),
      .upper_i     (upper),
      .data_o      (cell_data[i])
    );
  end

  // word returned by read, remove and pop
  assign rd_word = cell_data[ctl.rd_idx];

  // element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= ctl.cnt;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q         <= ctl.ok;
      read_value_q <= (ctl.ok && ctl.ret) ? rd_word : '0;
      res_count_q  <= ctl.cnt;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ok         = ok_q;
  assign out_o.read_value = read_value_q;
  assign out_o.count      = res_count_q;
  assign out_o.empty_res  = (res_count_q == '0);

endmodule
